FILE: rtl/fofq_pkg.sv
`default_nettype none
package fofq_pkg;

	// One queued item, classified by the front part.
	typedef struct packed {
		logic [63:0] addr;
		logic [31:0] size;
		logic [31:0] others;
		logic [31:0] rnd;
		logic        reject;
		logic [31:0] target;
	} fofq_item_t;

	typedef struct packed {
		logic        kind;
		logic [63:0] addr;
		logic [31:0] size;
		logic        acc;
		logic [5:0]  hcount;
		logic [31:0] hbytes;
		logic [31:0] miss;
		logic        last;
	} fofq_result_t;

	localparam logic KIND_EVICT   = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_REJECT,
		ST_SCAN,
		ST_SCAN_W,
		ST_EMIT,
		ST_EMIT_W,
		ST_MOD,
		ST_SWAP_RD,
		ST_SWAP_WR,
		ST_SWAP_WR2,
		ST_VERDICT
	} fofq_state_t;

endpackage
`default_nettype wire

FILE: rtl/fofq_ram.sv
`default_nettype none
module fofq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire                     clk,
	input  wire                     wr_en,
	input  wire [$clog2(DEPTH)-1:0] wr_addr,
	input  wire [WIDTH-1:0]         wr_data,
	input  wire [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]        rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end
endmodule
`default_nettype wire

FILE: rtl/fofq_front.sv
`default_nettype none
module fofq_front (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         in_valid,
	output logic                        in_ready,
	input  wire [159:0]                 in_data,
	input  wire [31:0]                  capacity,
	output logic                        q_valid,
	output fofq_pkg::fofq_item_t        q_item,
	input  wire                         q_pop
);
	fofq_pkg::fofq_item_t slot_q [2];
	fofq_pkg::fofq_item_t item;
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic [1:0]           fill_q;
	logic                 push;
	logic [32:0]          demand;

	// The object is refused when the other branches plus its size overflow the capacity.
	always_comb begin
		item.addr   = in_data[63:0];
		item.size   = in_data[95:64];
		item.others = in_data[127:96];
		item.rnd    = in_data[159:128];
		demand      = {1'b0, item.others} + {1'b0, item.size};
		item.reject = {1'b0, capacity} < demand;
		item.target = capacity - item.size;
	end

	assign in_ready = (fill_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (fill_q != 2'd0);
	assign q_item   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			fill_q <= fill_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule
`default_nettype wire

FILE: rtl/fofq_back.sv
`default_nettype none
module fofq_back #(
	parameter int DEPTH = 32
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          q_valid,
	input  fofq_pkg::fofq_item_t         q_item,
	output logic                         q_pop,
	output logic                         out_valid,
	input  wire                          out_ready,
	output fofq_pkg::fofq_result_t       out_res
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	fofq_pkg::fofq_state_t state_q, state_d;
	fofq_pkg::fofq_item_t  item_q;
	fofq_pkg::fofq_result_t res_q;
	logic          out_valid_q;
	logic [CW-1:0] cnt_q, k_q, i_q, rem_q;
	logic [31:0]   bytes_q, bb_q, miss_q, rnd_q;
	logic [4:0]    bit_q;
	logic [63:0]   ins_q, ins_bytes_q;

	logic          wr_en;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [95:0]   wr_data, rd_data;
	logic          out_free, evict_more, res_load;
	logic [CW-1:0] fcnt, rem_next;
	logic [CW:0]   rem_sh;
	logic [31:0]   fbytes;
	logic [32:0]   held_sum;

	fofq_ram #(.WIDTH(96), .DEPTH(DEPTH)) u_store (
		.clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
		.rd_addr(rd_addr), .rd_data(rd_data)
	);

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_res   = res_q;
	assign fcnt      = k_q + CW'(1);
	assign fbytes    = bb_q + item_q.size;
	assign held_sum  = {1'b0, item_q.others} + {1'b0, bb_q};
	// Evict while the bytes do not fit, or once more when the store is full.
	assign evict_more = ((k_q != '0) && ({1'b0, item_q.target} < held_sum)) || (k_q == FULL);
	assign rem_sh    = {rem_q, rnd_q[31]};
	assign rem_next  = (rem_sh >= {1'b0, cnt_q}) ? CW'(rem_sh - {1'b0, cnt_q}) : rem_sh[CW-1:0];

	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		wr_en    = 1'b0;
		res_load = 1'b0;
		wr_addr  = k_q[AW-1:0];
		wr_data  = {item_q.size, item_q.addr};
		rd_addr  = AW'(k_q - CW'(1));
		unique case (state_q)
			fofq_pkg::ST_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = q_item.reject ? fofq_pkg::ST_REJECT : fofq_pkg::ST_SCAN;
				end
			end
			fofq_pkg::ST_REJECT: begin
				if (out_free) begin
					res_load = 1'b1;
					state_d  = fofq_pkg::ST_IDLE;
				end
			end
			fofq_pkg::ST_SCAN: begin
				state_d = evict_more ? fofq_pkg::ST_SCAN_W : fofq_pkg::ST_EMIT;
			end
			fofq_pkg::ST_SCAN_W: state_d = fofq_pkg::ST_SCAN;
			fofq_pkg::ST_EMIT: begin
				rd_addr = AW'(i_q - CW'(1));
				if (i_q != k_q) begin
					state_d = fofq_pkg::ST_EMIT_W;
				end else begin
					wr_en   = 1'b1;
					state_d = fofq_pkg::ST_MOD;
				end
			end
			fofq_pkg::ST_EMIT_W: begin
				rd_addr = AW'(i_q - CW'(1));
				if (out_free) begin
					res_load = 1'b1;
					state_d  = fofq_pkg::ST_EMIT;
				end
			end
			fofq_pkg::ST_MOD: begin
				if (bit_q == 5'd0) state_d = fofq_pkg::ST_SWAP_RD;
			end
			fofq_pkg::ST_SWAP_RD: begin
				rd_addr = rem_q[AW-1:0];
				state_d = fofq_pkg::ST_SWAP_WR;
			end
			fofq_pkg::ST_SWAP_WR: begin
				rd_addr = rem_q[AW-1:0];
				wr_en   = 1'b1;
				wr_addr = AW'(cnt_q - CW'(1));
				wr_data = rd_data;
				state_d = fofq_pkg::ST_SWAP_WR2;
			end
			fofq_pkg::ST_SWAP_WR2: begin
				wr_en   = 1'b1;
				wr_addr = rem_q[AW-1:0];
				state_d = fofq_pkg::ST_VERDICT;
			end
			fofq_pkg::ST_VERDICT: begin
				if (out_free) begin
					res_load = 1'b1;
					state_d  = fofq_pkg::ST_IDLE;
				end
			end
			default: state_d = fofq_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fofq_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			bytes_q     <= '0;
			miss_q      <= '0;
			ins_q       <= '0;
			ins_bytes_q <= '0;
		end else begin
			state_q <= state_d;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				fofq_pkg::ST_REJECT: begin
					if (out_free) miss_q <= miss_q + 32'd1;
				end
				fofq_pkg::ST_EMIT: begin
					if (i_q == k_q) begin
						cnt_q   <= fcnt;
						bytes_q <= fbytes;
					end
				end
				fofq_pkg::ST_VERDICT: begin
					if (out_free) begin
						ins_q       <= ins_q + 64'd1;
						ins_bytes_q <= ins_bytes_q + {32'd0, item_q.size};
					end
				end
				default: ;
			endcase
		end
	end

	// Working registers of the current item, no reset needed.
	always_ff @(posedge clk) begin
		case (state_q)
			fofq_pkg::ST_IDLE: begin
				item_q <= q_item;
				k_q    <= cnt_q;
				i_q    <= cnt_q;
				bb_q   <= bytes_q;
			end
			fofq_pkg::ST_REJECT: begin
				if (out_free) begin
					res_q <= '{kind: fofq_pkg::KIND_VERDICT, addr: item_q.addr,
						size: item_q.size, acc: 1'b0, hcount: 6'(cnt_q),
						hbytes: bytes_q, miss: miss_q + 32'd1, last: 1'b1};
				end
			end
			fofq_pkg::ST_SCAN_W: begin
				bb_q <= bb_q - rd_data[95:64];
				k_q  <= k_q - CW'(1);
			end
			fofq_pkg::ST_EMIT: begin
				rem_q <= '0;
				rnd_q <= item_q.rnd;
				bit_q <= 5'd31;
			end
			fofq_pkg::ST_EMIT_W: begin
				if (out_free) begin
					res_q <= '{kind: fofq_pkg::KIND_EVICT, addr: rd_data[63:0],
						size: rd_data[95:64], acc: 1'b0, hcount: 6'(fcnt),
						hbytes: fbytes, miss: miss_q, last: 1'b0};
					i_q <= i_q - CW'(1);
				end
			end
			fofq_pkg::ST_MOD: begin
				rem_q <= rem_next;
				rnd_q <= {rnd_q[30:0], 1'b0};
				bit_q <= bit_q - 5'd1;
			end
			fofq_pkg::ST_VERDICT: begin
				if (out_free) begin
					res_q <= '{kind: fofq_pkg::KIND_VERDICT, addr: 64'd0, size: 32'd0,
						acc: 1'b1, hcount: 6'(cnt_q), hbytes: bytes_q, miss: miss_q,
						last: 1'b1};
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

FILE: rtl/freed_object_quarantine.sv
// A refused object goes from the queue through the reject state to its verdict; an accepted
// one walks the evicted entries to size the run, presents one result per eviction, takes the
// modulo of the swap position (bit-serial remainder), then does classification, insert, swap
// and verdict, plus any output stall. The back part holds one item at a time, its pace set
// by the eviction walk and the modulo unit; a two-entry queue lets the input side run ahead.
// Reset is asynchronous, active low, and clears counts, statistics and queue, not the store.
`default_nettype none
module freed_object_quarantine #(
	parameter int DEPTH = 32
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          cfg_wr_en,
	input  wire [31:0]   cfg_wr_data,
	input  wire          s_axis_tvalid,
	output logic         s_axis_tready,
	// object_address, entry_size, others_bytes, random_value
	input  wire [159:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  wire          m_axis_tready,
	// freed_address, freed_size, accepted, held_count, held_bytes, miss_total, zero pad
	output logic [167:0] m_axis_tdata,
	// result_kind
	output logic         m_axis_tuser,
	output logic         m_axis_tlast
);
	logic [31:0]            capacity_q;
	logic                   q_valid, q_pop;
	fofq_pkg::fofq_item_t   q_item;
	fofq_pkg::fofq_result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= '0;
		end else if (cfg_wr_en) begin
			capacity_q <= cfg_wr_data;
		end
	end

	fofq_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_data(s_axis_tdata), .capacity(capacity_q), .q_valid(q_valid), .q_item(q_item),
		.q_pop(q_pop)
	);

	fofq_back #(.DEPTH(DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_res(res)
	);

	assign m_axis_tdata = {1'b0, res.miss, res.hbytes, res.hcount, res.acc, res.size, res.addr};
	assign m_axis_tuser = res.kind;
	assign m_axis_tlast = res.last;
endmodule
`default_nettype wire

FILE: rtl/fofq_checker.sv
`default_nettype none
module fofq_checker #(
	parameter int DEPTH = 32
) (
	input wire         clk,
	input wire         arst_n,
	input wire         m_axis_tvalid,
	input wire         m_axis_tready,
	input wire [167:0] m_axis_tdata,
	input wire         m_axis_tuser,
	input wire         m_axis_tlast
);
	// A verdict, and only a verdict, closes a run.
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == m_axis_tuser))
		else $error("tlast and result kind disagree");

	// Eviction results never claim the object was taken.
	a_evict_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> !m_axis_tdata[96])
		else $error("eviction result marked accepted");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[102:97] <= 6'(DEPTH)) || (DEPTH > 63))
		else $error("held count beyond depth");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled result changed");
endmodule

bind freed_object_quarantine fofq_checker #(.DEPTH(DEPTH)) u_fofq_checker (.*);
`default_nettype wire
